// ===== rtl/rhc_pkg.sv =====
`default_nettype none

package rhc_pkg;

	// channel and result widths
	localparam int CH_W      = 8;
	localparam int HUE_W     = 10;
	localparam int IN_DATA_W = 24;   // red, green, blue
	localparam int OUT_DATA_W = 32;  // hue, sat, val, zero pad

	// divider sizing: quotients of both divisions fit in 8 bits
	localparam int SAT_NUM_W = 17;   // 510*delta + max <= 130305
	localparam int HUE_NUM_W = 15;   // 120*num + delta <= 30855
	localparam int DEN_W     = 9;    // 2*max or 2*delta <= 510
	localparam int QUO_W     = 8;
	localparam int TAG_W     = 9;

	// hue sector offsets in degrees
	localparam logic [8:0] HUE_OFF_0   = 9'd0;
	localparam logic [8:0] HUE_OFF_60  = 9'd60;
	localparam logic [8:0] HUE_OFF_120 = 9'd120;
	localparam logic [8:0] HUE_OFF_180 = 9'd180;
	localparam logic [8:0] HUE_OFF_240 = 9'd240;
	localparam logic [8:0] HUE_OFF_300 = 9'd300;
	localparam logic [9:0] HUE_FULL    = 10'd360;
	localparam logic [9:0] HUE_NONE    = 10'h3FF;  // -1, achromatic

endpackage

`default_nettype wire

// ===== rtl/rhc_div_pipe.sv =====
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage.
// The caller guarantees num < den * 2**QUO_W. A tag rides along unchanged.
module rhc_div_pipe #(
	parameter int NUM_W = rhc_pkg::SAT_NUM_W,
	parameter int DEN_W = rhc_pkg::DEN_W,
	parameter int QUO_W = rhc_pkg::QUO_W,
	parameter int TAG_W = rhc_pkg::TAG_W
) (
	input  wire logic             clk,
	input  wire logic [QUO_W-1:0] en,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	input  wire logic [TAG_W-1:0] tag_in,
	output logic      [QUO_W-1:0] quo,
	output logic      [TAG_W-1:0] tag_out
);
	import rhc_pkg::*;

	localparam int CW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

	logic [NUM_W-1:0] rem_s [QUO_W];
	logic [DEN_W-1:0] den_s [QUO_W];
	logic [QUO_W-1:0] quo_s [QUO_W];
	logic [TAG_W-1:0] tag_s [QUO_W];

	genvar k;
	generate
		for (k = 0; k < QUO_W; k++) begin : g_stg
			logic [NUM_W-1:0] rem_src;
			logic [DEN_W-1:0] den_src;
			logic [QUO_W-1:0] quo_src;
			logic [TAG_W-1:0] tag_src;
			logic [CW-1:0]    rem_ext;
			logic [CW-1:0]    trial;
			logic [CW-1:0]    diff;
			logic             take;

			if (k == 0) begin : g_first
				assign rem_src = num;
				assign den_src = den;
				assign quo_src = '0;
				assign tag_src = tag_in;
			end else begin : g_next
				assign rem_src = rem_s[k-1];
				assign den_src = den_s[k-1];
				assign quo_src = quo_s[k-1];
				assign tag_src = tag_s[k-1];
			end

			assign rem_ext = CW'(rem_src);
			assign trial   = CW'(den_src) << (QUO_W - 1 - k);
			assign diff    = rem_ext - trial;
			assign take    = (rem_ext >= trial);

			always_ff @(posedge clk) begin
				if (en[k]) begin
					quo_s[k] <= quo_src | (QUO_W'(take) << (QUO_W - 1 - k));
					tag_s[k] <= tag_src;
				end
			end

			// remainder and divisor are not needed after the last bit
			if (k < QUO_W - 1) begin : g_rem
				always_ff @(posedge clk) begin
					if (en[k]) begin
						rem_s[k] <= take ? diff[NUM_W-1:0] : rem_src;
						den_s[k] <= den_src;
					end
				end
			end
		end
	endgenerate

	assign quo     = quo_s[QUO_W-1];
	assign tag_out = tag_s[QUO_W-1];

endmodule

`default_nettype wire

// ===== rtl/rgb_to_hsv_convert.sv =====
`default_nettype none

// RGB to HSV converter for 8-bit pixels. One pixel request enters on the
// s_ side and one HSV result leaves on the m_ side, in order. The block takes
// a new pixel every clock cycle unless a stalled output has filled the whole
// pipeline. It has twelve register stages: the accepting edge loads the first
// one; the result sits in the last, the output register. They are the two
// 8-stage restoring dividers (one quotient bit per stage) that form saturation
// and hue, plus three stages ahead of them (max/min, sector select, numerator
// build) and one after them (hue offset, wrap and achromatic override).
// Each stage stalls only when it is full and the stage after it cannot move,
// so bubbles are squeezed out and a stalled output does not block accepting
// new pixels until the whole pipeline is full. Value is the largest channel;
// saturation is round(255*delta/max); hue is 0..359 or -1 for gray or black.
module rgb_to_hsv_convert (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// [7:0] red_in, [15:8] green_in, [23:16] blue_in
	input  wire logic [rhc_pkg::IN_DATA_W-1:0]    s_tdata,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// [9:0] hue_out (signed), [17:10] sat_out, [25:18] val_out, [31:26] zero
	output logic      [rhc_pkg::OUT_DATA_W-1:0]   m_tdata
);
	import rhc_pkg::*;

	localparam int NSTG = QUO_W + 4;

	// largest channel select; ties go to red, then green
	localparam logic [1:0] SEL_RED   = 2'd0;
	localparam logic [1:0] SEL_GREEN = 2'd1;
	localparam logic [1:0] SEL_BLUE  = 2'd2;

	// ---------------------------------------------------------------
	// Valid chain and per-stage enables
	// ---------------------------------------------------------------
	logic [NSTG-1:0] vld_s;
	logic [NSTG-1:0] en;

	always_comb begin
		en[NSTG-1] = !vld_s[NSTG-1] || m_tready;
		for (int i = NSTG - 2; i >= 0; i--) begin
			en[i] = !vld_s[i] || en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0]) begin
				vld_s[0] <= s_tvalid;
			end
			for (int i = 1; i < NSTG; i++) begin
				if (en[i]) begin
					vld_s[i] <= vld_s[i-1];
				end
			end
		end
	end

	assign s_tready = en[0];
	assign m_tvalid = vld_s[NSTG-1];

	// ---------------------------------------------------------------
	// Stage 1: max, min and which channel is largest
	// ---------------------------------------------------------------
	logic [CH_W-1:0] red, green, blue;
	logic [CH_W-1:0] max_c, min_c;
	logic [1:0]      sel_c;

	assign red   = s_tdata[CH_W-1:0];
	assign green = s_tdata[2*CH_W-1:CH_W];
	assign blue  = s_tdata[3*CH_W-1:2*CH_W];

	always_comb begin
		max_c = red;
		sel_c = SEL_RED;
		if (green > max_c) begin
			max_c = green;
			sel_c = SEL_GREEN;
		end
		if (blue > max_c) begin
			max_c = blue;
			sel_c = SEL_BLUE;
		end
		min_c = red;
		if (green < min_c) min_c = green;
		if (blue < min_c) min_c = blue;
	end

	logic [CH_W-1:0] red_s1, green_s1, blue_s1, max_s1, min_s1;
	logic [1:0]      sel_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			red_s1   <= red;
			green_s1 <= green;
			blue_s1  <= blue;
			max_s1   <= max_c;
			min_s1   <= min_c;
			sel_s1   <= sel_c;
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: delta, half-sector numerator and hue offset
	// ---------------------------------------------------------------
	logic [CH_W-1:0] delta_c;
	logic [CH_W:0]   diff_c;     // signed channel difference, 9 bits
	logic            pos_c;      // first half of the sector
	logic [CH_W:0]   num_wide_c;
	logic [8:0]      off_c;

	assign delta_c = max_s1 - min_s1;

	always_comb begin
		case (sel_s1)
			SEL_RED: begin
				diff_c = {1'b0, green_s1} - {1'b0, blue_s1};
				pos_c  = (green_s1 >= blue_s1);
				off_c  = pos_c ? HUE_OFF_0 : HUE_OFF_300;
			end
			SEL_GREEN: begin
				diff_c = {1'b0, blue_s1} - {1'b0, red_s1};
				pos_c  = (blue_s1 > red_s1);
				off_c  = pos_c ? HUE_OFF_120 : HUE_OFF_60;
			end
			SEL_BLUE: begin
				diff_c = {1'b0, red_s1} - {1'b0, green_s1};
				pos_c  = (red_s1 > green_s1);
				off_c  = pos_c ? HUE_OFF_240 : HUE_OFF_180;
			end
			default: begin
				diff_c = '0;
				pos_c  = 1'b1;
				off_c  = HUE_OFF_0;
			end
		endcase
		// second half of a sector counts up from the far edge
		num_wide_c = pos_c ? diff_c : diff_c + {1'b0, delta_c};
	end

	logic [CH_W-1:0] delta_s2, num_s2, max_s2;
	logic [8:0]      off_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			delta_s2 <= delta_c;
			num_s2   <= num_wide_c[CH_W-1:0];
			max_s2   <= max_s1;
			off_s2   <= off_c;
		end
	end

	// ---------------------------------------------------------------
	// Stage 3: dividends and divisors, constants by shift and add
	// ---------------------------------------------------------------
	logic [SAT_NUM_W-1:0] sat_num_s3;
	logic [DEN_W-1:0]     sat_den_s3;
	logic [HUE_NUM_W-1:0] hue_num_s3;
	logic [DEN_W-1:0]     hue_den_s3;
	logic [TAG_W-1:0]     sat_tag_s3;
	logic [TAG_W-1:0]     hue_tag_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			// 510*delta + max = 512*delta - 2*delta + max
			sat_num_s3 <= {delta_s2, 9'b0} - {8'b0, delta_s2, 1'b0} + {9'b0, max_s2};
			sat_den_s3 <= {max_s2, 1'b0};
			// 120*num + delta = 128*num - 8*num + delta
			hue_num_s3 <= {num_s2, 7'b0} - {4'b0, num_s2, 3'b0} + {7'b0, delta_s2};
			hue_den_s3 <= {delta_s2, 1'b0};
			// gray or black when delta is zero
			sat_tag_s3 <= {(delta_s2 == '0), max_s2};
			hue_tag_s3 <= off_s2;
		end
	end

	// ---------------------------------------------------------------
	// Stages 4..11: saturation and hue dividers side by side
	// ---------------------------------------------------------------
	logic [QUO_W-1:0] sat_quo, hue_quo;
	logic [TAG_W-1:0] sat_tag, hue_tag;

	rhc_div_pipe #(
		.NUM_W (SAT_NUM_W),
		.DEN_W (DEN_W),
		.QUO_W (QUO_W),
		.TAG_W (TAG_W)
	) u_sat_div (
		.clk     (clk),
		.en      (en[3 +: QUO_W]),
		.num     (sat_num_s3),
		.den     (sat_den_s3),
		.tag_in  (sat_tag_s3),
		.quo     (sat_quo),
		.tag_out (sat_tag)
	);

	rhc_div_pipe #(
		.NUM_W (HUE_NUM_W),
		.DEN_W (DEN_W),
		.QUO_W (QUO_W),
		.TAG_W (TAG_W)
	) u_hue_div (
		.clk     (clk),
		.en      (en[3 +: QUO_W]),
		.num     (hue_num_s3),
		.den     (hue_den_s3),
		.tag_in  (hue_tag_s3),
		.quo     (hue_quo),
		.tag_out (hue_tag)
	);

	// ---------------------------------------------------------------
	// Stage 12: hue offset, wrap at 360, achromatic override
	// ---------------------------------------------------------------
	logic            achrom;
	logic [HUE_W-1:0] hue_sum, hue_wrap;

	assign achrom   = sat_tag[TAG_W-1];
	assign hue_sum  = {1'b0, hue_tag} + {2'b0, hue_quo};
	assign hue_wrap = (hue_sum >= HUE_FULL) ? hue_sum - HUE_FULL : hue_sum;

	logic [HUE_W-1:0] hue_s12;
	logic [CH_W-1:0]  sat_s12, val_s12;

	always_ff @(posedge clk) begin
		if (en[NSTG-1]) begin
			hue_s12 <= achrom ? HUE_NONE : hue_wrap;
			sat_s12 <= achrom ? '0 : sat_quo;
			val_s12 <= sat_tag[CH_W-1:0];
		end
	end

	assign m_tdata = {(OUT_DATA_W - HUE_W - 2*CH_W)'(0), val_s12, sat_s12, hue_s12};

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_achrom_match: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((sat_s12 == '0) == (hue_s12 == HUE_NONE)))
		else $error("saturation and achromatic hue disagree");

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (hue_s12 == HUE_NONE || hue_s12 < HUE_FULL))
		else $error("hue out of range");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready && (&vld_s)))
		else $error("input stalled with room in pipeline");

endmodule

`default_nettype wire
